[hw/rtl/uudecode_line_checksum_top_macros.svh]
// Assertion macros for the uudecode line checksum block.
// Used by uudecode_line_checksum_top; the macros name its clock and reset ports.
`ifndef UUDECODE_LINE_CHECKSUM_TOP_MACROS_SVH
`define UUDECODE_LINE_CHECKSUM_TOP_MACROS_SVH

// Checked at every rising clock edge outside reset.
`define UUDLC_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("uudecode line checksum check failed");

// Checked in the cycle after the antecedent, outside reset.
`define UUDLC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("uudecode line checksum sequence check failed");

`endif

[hw/rtl/uudlc_pkg.sv]
// Shared types and constants of the uudecode line checksum block.
// Used by uudecode_line_checksum_top; depends on nothing else.
package uudlc_pkg;

   // Result kinds.
   localparam logic [1:0] KIND_DATA    = 2'd0;
   localparam logic [1:0] KIND_OK      = 2'd1;
   localparam logic [1:0] KIND_BAD_LEN = 2'd2;
   localparam logic [1:0] KIND_BAD_CNT = 2'd3;

   // Accepted byte counts and the character count a full line must have.
   localparam logic [5:0] LEN_FULL       = 6'd45;
   localparam logic [5:0] LEN_SHORT      = 6'd34;
   localparam logic [6:0] FULL_LINE_CHARS = 7'd61;
   localparam logic [7:0] CHAR_OFFSET    = 8'h20;
   localparam logic [6:0] POS_MAX        = 7'd127;

   // Result queue geometry.
   localparam int QDEPTH = 8;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = QPTR_W + 1;
   localparam int MAX_RESULTS = 4;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data_byte;
      logic [7:0]  line_bytes;
      logic [31:0] running_sum;
      logic        last;
   } rsp_word_type;

   // Number of four-character groups decoded for an accepted byte count.
   function automatic logic [3:0] group_limit(input logic [5:0] len);
      logic [3:0] lim;
      lim = 4'd0;
      case (len)
         LEN_FULL:  lim = 4'd15;
         LEN_SHORT: lim = 4'd12;
         default:   lim = 4'd0;
      endcase
      return lim;
   endfunction

endpackage

[hw/rtl/uudecode_line_checksum_top.sv]
// Top level of the uudecode line checksum block: decoder, running sum, result queue.
// Depends on uudlc_pkg and uudecode_line_checksum_top_macros.svh.
//
// Usage: characters of one uuencoded line enter on the req_ channel, one word
// per character, the length character first and req_end_of_line on the last.
// req_clear_sum zeroes the running sum before that character is handled.
// Each group of four data characters yields three data-byte words on the
// rsp_ channel; the end-of-line character adds a status word (ok, bad length
// code, wrong character count). rsp_last marks the final word from one input.
// The words for a character are written into the result queue when it is taken.
// Throughput: one character per cycle while the eight-entry result queue
// holds four words or fewer; the queue drains one word per cycle, so a
// 45-byte line of 61 characters streams without a stall while the receiver
// keeps up.
// Reset clears the line state, the sum and the queue; nothing is pending.
// When the receiver stalls, words wait in the queue and req_ready drops
// once more than four are waiting; no word is lost or repeated.
`include "uudecode_line_checksum_top_macros.svh"

module uudecode_line_checksum_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_code_char,
   input  logic        req_end_of_line,
   input  logic        req_clear_sum,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [7:0]  rsp_line_bytes,
   output logic [31:0] rsp_running_sum,
   output logic        rsp_last
);

   // Line state.
   logic [6:0]  char_pos_ff, char_pos_in;
   logic [5:0]  len_code_ff, len_code_in;
   logic [17:0] accum_ff, accum_in;
   logic [1:0]  in_group_ff, in_group_in;
   logic [3:0]  groups_ff, groups_in;
   logic        line_bad_ff, line_bad_in;
   logic [31:0] sum_ff, sum_in;

   // Result queue.
   uudlc_pkg::rsp_word_type queue_ff [uudlc_pkg::QDEPTH];
   logic [uudlc_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [uudlc_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [uudlc_pkg::QCNT_W-1:0] count_ff, count_in;

   logic        accept;
   logic        pop;
   logic [31:0] base_sum;
   logic [5:0]  six_bits;
   logic [23:0] full_group;
   logic        group_fire;
   logic [6:0]  pos_after;
   logic [7:0]  len_char;
   logic        len_ok;
   logic [1:0]  status_kind;
   logic [9:0]  part1, part2, part3;
   logic [31:0] sum1, sum2, sum3;
   logic [2:0]  n_words;
   uudlc_pkg::rsp_word_type words [uudlc_pkg::MAX_RESULTS];

   // Byte count of the current line, including a length character taken now.
   function automatic logic [5:0] len_code_in_line();
      return (char_pos_ff == 7'd0) ? len_char[5:0] : len_code_ff;
   endfunction

   // Handshakes: room for a full set of words for one character.
   assign req_ready = (count_ff <= uudlc_pkg::QCNT_W'(uudlc_pkg::MAX_RESULTS));
   assign accept    = req_valid & req_ready;
   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid & rsp_ready;

   // Character decode and line state update.
   always_comb begin
      base_sum    = req_clear_sum ? 32'd0 : sum_ff;
      six_bits    = 6'(req_code_char - uudlc_pkg::CHAR_OFFSET);
      full_group  = {accum_ff, six_bits};
      len_char    = req_code_char - uudlc_pkg::CHAR_OFFSET;
      len_ok      = (len_char == {2'b00, uudlc_pkg::LEN_FULL} ||
                     len_char == {2'b00, uudlc_pkg::LEN_SHORT});
      group_fire  = 1'b0;
      char_pos_in = char_pos_ff;
      len_code_in = len_code_ff;
      accum_in    = accum_ff;
      in_group_in = in_group_ff;
      groups_in   = groups_ff;
      line_bad_in = line_bad_ff;

      if (char_pos_ff == 7'd0) begin
         if (len_ok) begin
            len_code_in = len_char[5:0];
            line_bad_in = 1'b0;
         end else begin
            len_code_in = 6'd0;
            line_bad_in = 1'b1;
         end
      end else if (!line_bad_ff && groups_ff < uudlc_pkg::group_limit(len_code_ff)) begin
         if (in_group_ff == 2'd3) begin
            group_fire  = 1'b1;
            accum_in    = 18'd0;
            in_group_in = 2'd0;
            groups_in   = groups_ff + 4'd1;
         end else begin
            accum_in    = {accum_ff[11:0], six_bits};
            in_group_in = in_group_ff + 2'd1;
         end
      end

      pos_after   = (char_pos_ff < uudlc_pkg::POS_MAX) ? char_pos_ff + 7'd1 : char_pos_ff;
      char_pos_in = pos_after;

      // A new line starts after the end-of-line character; the sum is kept.
      if (req_end_of_line) begin
         char_pos_in = 7'd0;
         len_code_in = 6'd0;
         accum_in    = 18'd0;
         in_group_in = 2'd0;
         groups_in   = 4'd0;
         line_bad_in = 1'b0;
      end
   end

   // Status kind at end of line, using this line's length decision.
   always_comb begin
      if (char_pos_ff == 7'd0 && !len_ok) begin
         status_kind = uudlc_pkg::KIND_BAD_LEN;
      end else if (char_pos_ff != 7'd0 && line_bad_ff) begin
         status_kind = uudlc_pkg::KIND_BAD_LEN;
      end else if ((char_pos_ff == 7'd0 ? len_char[5:0] : len_code_ff) == uudlc_pkg::LEN_FULL
                   && pos_after != uudlc_pkg::FULL_LINE_CHARS) begin
         status_kind = uudlc_pkg::KIND_BAD_CNT;
      end else begin
         status_kind = uudlc_pkg::KIND_OK;
      end
   end

   // Running sums after each data byte, each one wide add off the base.
   always_comb begin
      part1 = {2'b00, full_group[23:16]};
      part2 = part1 + {2'b00, full_group[15:8]};
      part3 = part2 + {2'b00, full_group[7:0]};
      sum1  = base_sum + {22'd0, part1};
      sum2  = base_sum + {22'd0, part2};
      sum3  = base_sum + {22'd0, part3};
      sum_in = group_fire ? sum3 : base_sum;
   end

   // Assemble the words caused by this character, in order.
   always_comb begin
      n_words = {1'b0, group_fire, group_fire} + {2'b00, req_end_of_line};
      for (int i = 0; i < uudlc_pkg::MAX_RESULTS; i++) begin
         words[i] = '0;
      end
      if (group_fire) begin
         words[0].kind        = uudlc_pkg::KIND_DATA;
         words[0].data_byte   = full_group[23:16];
         words[0].running_sum = sum1;
         words[1].kind        = uudlc_pkg::KIND_DATA;
         words[1].data_byte   = full_group[15:8];
         words[1].running_sum = sum2;
         words[2].kind        = uudlc_pkg::KIND_DATA;
         words[2].data_byte   = full_group[7:0];
         words[2].running_sum = sum3;
      end
      if (req_end_of_line) begin
         words[group_fire ? 3 : 0].kind        = status_kind;
         words[group_fire ? 3 : 0].line_bytes  =
            (status_kind == uudlc_pkg::KIND_BAD_LEN) ? 8'd0 : {2'b00, len_code_in_line()};
         words[group_fire ? 3 : 0].running_sum = sum_in;
      end
      for (int i = 0; i < uudlc_pkg::MAX_RESULTS; i++) begin
         words[i].last = (3'(i) == n_words - 3'd1);
      end
   end

   // Queue pointers and fill count.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (accept) begin
         wr_ptr_in = wr_ptr_ff + n_words;
         count_in  = count_in + uudlc_pkg::QCNT_W'(n_words);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
         count_in  = count_in - 1'b1;
      end
   end

   // Control and line state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         char_pos_ff <= '0;
         len_code_ff <= '0;
         accum_ff    <= '0;
         in_group_ff <= '0;
         groups_ff   <= '0;
         line_bad_ff <= 1'b0;
         sum_ff      <= '0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
      end else begin
         if (accept) begin
            char_pos_ff <= char_pos_in;
            len_code_ff <= len_code_in;
            accum_ff    <= accum_in;
            in_group_ff <= in_group_in;
            groups_ff   <= groups_in;
            line_bad_ff <= line_bad_in;
            sum_ff      <= sum_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue entries: payload only, written at the write pointer onward.
   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < uudlc_pkg::MAX_RESULTS; i++) begin
            if (3'(i) < n_words) begin
               queue_ff[wr_ptr_ff + uudlc_pkg::QPTR_W'(i)] <= words[i];
            end
         end
      end
   end

   // Head of the queue drives the result ports.
   assign rsp_kind        = queue_ff[rd_ptr_ff].kind;
   assign rsp_data_byte   = queue_ff[rd_ptr_ff].data_byte;
   assign rsp_line_bytes  = queue_ff[rd_ptr_ff].line_bytes;
   assign rsp_running_sum = queue_ff[rd_ptr_ff].running_sum;
   assign rsp_last        = queue_ff[rd_ptr_ff].last;

   // The queue never holds more words than it has entries.
   `UUDLC_ASSERT(a_queue_bound, count_ff <= uudlc_pkg::QCNT_W'(uudlc_pkg::QDEPTH))
   // A status word always closes the words of its character.
   `UUDLC_ASSERT(a_status_last, !rsp_valid || rsp_kind == uudlc_pkg::KIND_DATA || rsp_last)
   // An end-of-line character leaves the line state at its start values.
   `UUDLC_ASSERT_NEXT(a_line_restart, accept && req_end_of_line,
      char_pos_ff == 7'd0 && in_group_ff == 2'd0 && groups_ff == 4'd0 && !line_bad_ff)

endmodule
